FILE: src/bed_pkg.sv
// Shared types and constants for the button and encoder debouncer.
package bed_pkg;

  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] ReleaseCountReset = 16'd100;

  localparam int unsigned PhaseW = 2;
  localparam logic [PhaseW-1:0] PhaseIdle  = 2'd0;
  localparam logic [PhaseW-1:0] PhaseOne   = 2'd1;
  localparam logic [PhaseW-1:0] PhaseThree = 2'd3;

  localparam int unsigned EnW   = 4;
  localparam int unsigned EnOk  = 0;
  localparam int unsigned EnEsc = 1;
  localparam int unsigned EnCcw = 2;
  localparam int unsigned EnCw  = 3;

  localparam logic KindSample = 1'b0;
  localparam logic KindDrop   = 1'b1;

  typedef struct packed {
    logic done;
    logic held;
    logic set_en;
  } btn_status_t;

  typedef struct packed {
    logic ok_press;
    logic esc_press;
    logic ccw_step;
    logic cw_step;
    logic ok_held;
    logic esc_held;
  } result_t;

endpackage

FILE: src/button_encoder_debouncer.sv
// Top level of the ok/esc button debouncer and rotary encoder decoder.
// Each accepted sample item is handled in the cycle it is accepted and gives one
// result item; a drop item clears the event enables and gives none. One item can
// be accepted every cycle: the result goes to an output register, and a single
// skid register absorbs one more result while the output side stalls, so in_stall
// rises only when both are full. An accepted result is registered in the output
// register, or in the skid register while the output side stalls. The release count
// register may be rewritten at any idle time and takes effect with the next item.
module button_encoder_debouncer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_kind,
  input  logic                       in_ok_level,
  input  logic                       in_esc_level,
  input  logic                       in_enc_high_level,
  input  logic                       in_enc_low_level,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_ok_press,
  output logic                       out_esc_press,
  output logic                       out_ccw_step,
  output logic                       out_cw_step,
  output logic                       out_ok_held,
  output logic                       out_esc_held,
  input  logic                       cfg_wr_en,
  input  logic [bed_pkg::CountW-1:0] cfg_wr_data
);

  logic [bed_pkg::CountW-1:0] release_count_r;
  logic [bed_pkg::PhaseW-1:0] phase_r, phase_nxt;
  logic [bed_pkg::EnW-1:0]    en_r, en_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       skid_valid_r, skid_valid_nxt;
  bed_pkg::result_t           out_r, out_nxt;
  bed_pkg::result_t           skid_r, skid_nxt;
  bed_pkg::result_t           res;
  bed_pkg::btn_status_t       ok_st, esc_st;
  logic                       accept, tick, res_valid, out_free;
  logic [bed_pkg::PhaseW-1:0] phase_in;
  logic [bed_pkg::EnW-1:0]    ev;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !in_stall;
  assign tick      = accept && (in_kind == bed_pkg::KindSample);
  assign res_valid = tick;
  assign out_free  = !out_valid_r || !out_stall;
  assign phase_in  = {~in_enc_high_level, ~in_enc_low_level};

  bed_button u_ok (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick          (tick),
    .pressed       (~in_ok_level),
    .release_count (release_count_r),
    .status        (ok_st)
  );

  bed_button u_esc (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick          (tick),
    .pressed       (~in_esc_level),
    .release_count (release_count_r),
    .status        (esc_st)
  );

  always_comb begin
    phase_nxt = phase_r;
    en_nxt    = en_r;
    ev        = '0;
    if (accept && (in_kind == bed_pkg::KindDrop)) begin
      en_nxt = '0;
    end else if (tick) begin
      phase_nxt = phase_in;
      en_nxt[bed_pkg::EnOk]  = en_r[bed_pkg::EnOk]  | ok_st.set_en;
      en_nxt[bed_pkg::EnEsc] = en_r[bed_pkg::EnEsc] | esc_st.set_en;
      if (phase_in != bed_pkg::PhaseIdle) begin
        en_nxt[bed_pkg::EnCcw] = 1'b1;
        en_nxt[bed_pkg::EnCw]  = 1'b1;
      end
      ev[bed_pkg::EnOk]  = ok_st.done;
      ev[bed_pkg::EnEsc] = esc_st.done;
      ev[bed_pkg::EnCcw] = (phase_in == bed_pkg::PhaseOne) && (phase_r == bed_pkg::PhaseThree);
      ev[bed_pkg::EnCw]  = (phase_in == bed_pkg::PhaseThree) && (phase_r == bed_pkg::PhaseOne);
    end
  end

  always_comb begin
    res.ok_press  = ev[bed_pkg::EnOk]  & en_nxt[bed_pkg::EnOk];
    res.esc_press = ev[bed_pkg::EnEsc] & en_nxt[bed_pkg::EnEsc];
    res.ccw_step  = ev[bed_pkg::EnCcw] & en_nxt[bed_pkg::EnCcw];
    res.cw_step   = ev[bed_pkg::EnCw]  & en_nxt[bed_pkg::EnCw];
    res.ok_held   = ok_st.held;
    res.esc_held  = esc_st.held;
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_nxt       = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_count_r <= bed_pkg::ReleaseCountReset;
      phase_r         <= bed_pkg::PhaseIdle;
      en_r            <= '0;
      out_valid_r     <= 1'b0;
      skid_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        release_count_r <= cfg_wr_data;
      end
      phase_r      <= phase_nxt;
      en_r         <= en_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_ok_press  = out_r.ok_press;
  assign out_esc_press = out_r.esc_press;
  assign out_ccw_step  = out_r.ccw_step;
  assign out_cw_step   = out_r.cw_step;
  assign out_ok_held   = out_r.ok_held;
  assign out_esc_held  = out_r.esc_held;

endmodule

FILE: src/bed_button.sv
// Hold counter for one active-low button, reporting completed presses.
module bed_button (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           tick,
  input  logic                           pressed,
  input  logic [bed_pkg::CountW-1:0]     release_count,
  output bed_pkg::btn_status_t           status
);

  logic [bed_pkg::CountW-1:0] count_r;
  logic [bed_pkg::CountW-1:0] count_nxt;

  always_comb begin
    count_nxt     = count_r;
    status.done   = 1'b0;
    status.set_en = 1'b0;
    if (tick) begin
      if (count_r == '0) begin
        if (pressed) begin
          count_nxt     = release_count;
          status.set_en = 1'b1;
        end
      end else if (!pressed) begin
        count_nxt   = count_r - 1'b1;
        status.done = (count_r == {{(bed_pkg::CountW-1){1'b0}}, 1'b1});
      end
    end
    status.held = (count_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

FILE: src/bed_checker.sv
// Port-level checker for the button and encoder debouncer, with its bind.
module bed_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_ok_press,
  input logic out_esc_press,
  input logic out_ccw_step,
  input logic out_cw_step,
  input logic out_ok_held,
  input logic out_esc_held
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("Result side not empty after reset.");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("Input stalled while no result is waiting.");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("Stalled result item was withdrawn.");

  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_cw_step && out_ccw_step))
    else $error("Both encoder directions reported in one item.");

  a_press_ends_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_ok_press || out_esc_press)) |->
      ((!out_ok_press || !out_ok_held) && (!out_esc_press || !out_esc_held)))
    else $error("Press reported while its button is still held.");

endmodule

bind button_encoder_debouncer bed_checker u_bed_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_ok_press  (out_ok_press),
  .out_esc_press (out_esc_press),
  .out_ccw_step  (out_ccw_step),
  .out_cw_step   (out_cw_step),
  .out_ok_held   (out_ok_held),
  .out_esc_held  (out_esc_held)
);

FILE: test/button_encoder_debouncer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ok/esc button debouncer and rotary encoder decoder.
module button_encoder_debouncer_test;

  localparam logic [bed_pkg::PhaseW-1:0] PhaseTwo = 2'd2;
  localparam logic [bed_pkg::PhaseW-1:0] GrayOrder [4] =
    '{bed_pkg::PhaseIdle, bed_pkg::PhaseOne, bed_pkg::PhaseThree, PhaseTwo};

  class debounce_predictor;
    logic [bed_pkg::CountW-1:0] release_count;
    logic [bed_pkg::CountW-1:0] ok_hold;
    logic [bed_pkg::CountW-1:0] esc_hold;
    logic [bed_pkg::PhaseW-1:0] enc_phase;
    logic [bed_pkg::EnW-1:0] enables;
    bed_pkg::result_t expected_q[$];
    int unsigned errors;

    function new();
      release_count = bed_pkg::ReleaseCountReset;
      ok_hold = '0;
      esc_hold = '0;
      enc_phase = bed_pkg::PhaseIdle;
      enables = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void tick_button(input bit pressed, input int unsigned en_idx,
                              inout logic [bed_pkg::CountW-1:0] count, output bit done);
      done = 1'b0;
      if (count == '0) begin
        if (pressed) begin
          enables[en_idx] = 1'b1;
          count = release_count;
        end
      end else if (!pressed) begin
        count = count - 1'b1;
        done = (count == '0);
      end
    endfunction

    function void note_item(input logic kind, input logic ok_level, input logic esc_level,
                            input logic hi_level, input logic lo_level);
      bed_pkg::result_t r;
      logic [bed_pkg::PhaseW-1:0] ph;
      bit ok_done;
      bit esc_done;
      if (kind == bed_pkg::KindDrop) begin
        enables = '0;
        return;
      end
      tick_button(!ok_level, bed_pkg::EnOk, ok_hold, ok_done);
      tick_button(!esc_level, bed_pkg::EnEsc, esc_hold, esc_done);
      ph = {!hi_level, !lo_level};
      if (ph != bed_pkg::PhaseIdle) begin
        enables[bed_pkg::EnCcw] = 1'b1;
        enables[bed_pkg::EnCw] = 1'b1;
      end
      r = '0;
      r.ok_press = ok_done && enables[bed_pkg::EnOk];
      r.esc_press = esc_done && enables[bed_pkg::EnEsc];
      if (ph != enc_phase) begin
        r.ccw_step = (ph == bed_pkg::PhaseOne) && (enc_phase == bed_pkg::PhaseThree) &&
                     enables[bed_pkg::EnCcw];
        r.cw_step = (ph == bed_pkg::PhaseThree) && (enc_phase == bed_pkg::PhaseOne) &&
                    enables[bed_pkg::EnCw];
        enc_phase = ph;
      end
      r.ok_held = (ok_hold != '0);
      r.esc_held = (esc_hold != '0);
      expected_q.push_back(r);
    endfunction

    function void check_field(input string label, input logic e, input logic a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %b, actual %b", $time, label, e, a);
      end
    endfunction

    function void check_result(input bed_pkg::result_t got);
      bed_pkg::result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %b", $time, got);
        return;
      end
      exp_r = expected_q.pop_front();
      check_field("ok_press", exp_r.ok_press, got.ok_press);
      check_field("esc_press", exp_r.esc_press, got.esc_press);
      check_field("ccw_step", exp_r.ccw_step, got.ccw_step);
      check_field("cw_step", exp_r.cw_step, got.cw_step);
      check_field("ok_held", exp_r.ok_held, got.ok_held);
      check_field("esc_held", exp_r.esc_held, got.esc_held);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_kind = bed_pkg::KindSample;
  logic in_ok_level = 1'b1;
  logic in_esc_level = 1'b1;
  logic in_enc_high_level = 1'b1;
  logic in_enc_low_level = 1'b1;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_ok_press;
  logic out_esc_press;
  logic out_ccw_step;
  logic out_cw_step;
  logic out_ok_held;
  logic out_esc_held;
  logic cfg_wr_en = 1'b0;
  logic [bed_pkg::CountW-1:0] cfg_wr_data = '0;

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned enc_idx = 0;
  bit enc_cw = 1'b1;
  debounce_predictor pred = new();

  button_encoder_debouncer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_ok_level(in_ok_level),
    .in_esc_level(in_esc_level),
    .in_enc_high_level(in_enc_high_level),
    .in_enc_low_level(in_enc_low_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_ok_press(out_ok_press),
    .out_esc_press(out_esc_press),
    .out_ccw_step(out_ccw_step),
    .out_cw_step(out_cw_step),
    .out_ok_held(out_ok_held),
    .out_esc_held(out_esc_held),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        pred.check_result({out_ok_press, out_esc_press, out_ccw_step, out_cw_step,
                           out_ok_held, out_esc_held});
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_item(input logic kind, input logic ok_level, input logic esc_level,
                           input logic hi_level, input logic lo_level);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_ok_level <= ok_level;
    in_esc_level <= esc_level;
    in_enc_high_level <= hi_level;
    in_enc_low_level <= lo_level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred.note_item(kind, ok_level, esc_level, hi_level, lo_level);
  endtask

  task automatic send_tick(input bit ok_dn, input bit esc_dn,
                           input logic [bed_pkg::PhaseW-1:0] ph);
    send_item(bed_pkg::KindSample, !ok_dn, !esc_dn, !ph[1], !ph[0]);
  endtask

  task automatic drain_results(input int unsigned extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pred.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic enter_phase(input bit do_write, input logic [bed_pkg::CountW-1:0] value,
                             input int unsigned gap, input int unsigned stall);
    drain_results(8);
    send_gap_pct = gap;
    stall_pct = stall;
    if (do_write) begin
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= value;
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      pred.release_count = value;
    end
  endtask

  task automatic random_items(input int unsigned n, input int unsigned press_pct);
    int unsigned roll;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 2) drain_results(0);
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        send_item(bed_pkg::KindDrop, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          if ($urandom_range(0, 99) < 20) enc_cw = !enc_cw;
          enc_idx = enc_cw ? (enc_idx + 1) % 4 : (enc_idx + 3) % 4;
        end else if (roll >= 90) begin
          enc_idx = $urandom_range(0, 3);
        end
        send_tick($urandom_range(0, 99) < press_pct, $urandom_range(0, 99) < press_pct,
                  GrayOrder[enc_idx]);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    enter_phase(1'b0, bed_pkg::ReleaseCountReset, 0, 0);
    random_items(120, 8);

    enter_phase(1'b1, 16'd2, 60, 0);
    while (pred.ok_hold != '0 || pred.esc_hold != '0) begin
      send_tick(1'b0, 1'b0, bed_pkg::PhaseIdle);
    end
    send_item(bed_pkg::KindDrop, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, bed_pkg::PhaseIdle);
    send_tick(1'b1, 1'b1, bed_pkg::PhaseIdle);
    // The drop clears the button enables, so these presses complete masked.
    send_item(bed_pkg::KindDrop, 1'b1, 1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, bed_pkg::PhaseIdle);
    send_tick(1'b0, 1'b0, bed_pkg::PhaseIdle);
    send_tick(1'b1, 1'b0, bed_pkg::PhaseOne);
    send_tick(1'b1, 1'b0, bed_pkg::PhaseThree);
    send_tick(1'b0, 1'b0, bed_pkg::PhaseOne);
    send_tick(1'b0, 1'b0, bed_pkg::PhaseOne);
    send_tick(1'b0, 1'b1, bed_pkg::PhaseIdle);
    send_tick(1'b0, 1'b1, PhaseTwo);
    send_tick(1'b0, 1'b0, bed_pkg::PhaseThree);
    send_tick(1'b0, 1'b0, bed_pkg::PhaseOne);
    // After a drop the encoder enable is set again by the same tick that steps.
    send_item(bed_pkg::KindDrop, 1'b0, 1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, bed_pkg::PhaseThree);
    send_tick(1'b1, 1'b1, bed_pkg::PhaseThree);
    send_tick(1'b0, 1'b0, bed_pkg::PhaseIdle);
    send_tick(1'b0, 1'b0, bed_pkg::PhaseIdle);
    random_items(70, 25);

    enter_phase(1'b1, 16'd1, 0, 60);
    random_items(80, 30);

    enter_phase(1'b1, 16'd0, 26, 26);
    random_items(60, 30);

    enter_phase(1'b1, 16'd7, 0, 0);
    random_items(80, 15);

    enter_phase(1'b1, 16'd3, 26, 26);
    random_items(60, 25);

    enter_phase(1'b1, 16'hFFFF, 0, 60);
    random_items(40, 25);

    drain_results(8);
    if (pred.errors == 0 && pred.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
src/bed_pkg.sv
src/bed_button.sv
src/button_encoder_debouncer.sv
src/bed_checker.sv
test/button_encoder_debouncer_test.sv
